### sv/mixacc_pkg.sv
// Shared constants and command codes for the mix bus accumulator.
package mixacc_pkg;

   // Store geometry.
   localparam int BUS_COUNT             = 9;
   localparam int FRAME_SAMPLES_DEFAULT = 160;

   // Field widths of one transfer.
   localparam int CMD_W    = 3;
   localparam int BUS_W    = 4;
   localparam int INDEX_W  = 8;
   localparam int WORD_W   = 32;
   localparam int VOLUME_W = 16;
   localparam int STEP_W   = 16;
   localparam int PCM_W    = 16;

   // Output clamp limit and Q1.15 scaling shift.
   localparam int PCM_MAX = 32767;
   localparam int Q_SHIFT = 15;

   // Bus numbers within the store.
   localparam logic [BUS_W-1:0] BUS_MAIN_L = 4'd0;
   localparam logic [BUS_W-1:0] BUS_MAIN_R = 4'd1;
   localparam logic [BUS_W-1:0] BUS_MAIN_S = 4'd2;
   localparam logic [BUS_W-1:0] BUS_AUXB_L = 4'd6;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_RAMP     = 3'd0,
      CMD_VOL_MIX  = 3'd1,
      CMD_ADD      = 3'd2,
      CMD_READ     = 3'd3,
      CMD_SET_MAIN = 3'd4,
      CMD_SET_OPP  = 3'd5,
      CMD_AUXB_MIX = 3'd6,
      CMD_PCM_OUT  = 3'd7
   } cmd_type;

endpackage

### sv/mixacc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mixacc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1440
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/audio_mix_bus_accumulator.sv
// Top level of the mix bus accumulator: command sequencer around the bus store.
//
// Usage: a command transfer is taken at a rising clock edge with start high and
// busy low. Each command touches one element position (req_index) on one or
// more of the nine buses held in a single-port-write, single-port-read RAM.
// Every memory access passes through an issue state (address out, product
// registered) and then an apply state (read data back, write-back). Ramp, mix,
// add and read make one access each, the aux B replace two, and set main, set
// opposite and output three. A command whose position or bus is out of range
// makes no access but still passes once through the issue and apply states.
// The strict read-then-write order per access means no two accesses overlap,
// so no forwarding is needed.
// Read and output commands give one result: rsp_strobe is high for exactly one
// cycle, the cycle right after the last apply cycle, in which busy is already
// low. The receiver cannot stall; it must take the result in that cycle.
// Other commands give nothing.
// After reset the block clears the whole store, one word per cycle, all
// 9 * FRAME_SAMPLES words (1440 by default), with busy held high.
module audio_mix_bus_accumulator #(
   parameter int FRAME_SAMPLES = mixacc_pkg::FRAME_SAMPLES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic        [mixacc_pkg::CMD_W-1:0]    req_cmd,
   input  logic        [mixacc_pkg::BUS_W-1:0]    req_bus,
   input  logic        [mixacc_pkg::INDEX_W-1:0]  req_index,
   input  logic signed [mixacc_pkg::WORD_W-1:0]   req_sample,
   input  logic        [mixacc_pkg::VOLUME_W-1:0] req_volume,
   input  logic signed [mixacc_pkg::WORD_W-1:0]   req_ramp_start,
   input  logic signed [mixacc_pkg::STEP_W-1:0]   req_ramp_step,
   output logic                                   rsp_strobe,
   output logic signed [mixacc_pkg::WORD_W-1:0]   rsp_word,
   output logic signed [mixacc_pkg::PCM_W-1:0]    rsp_left_pcm,
   output logic signed [mixacc_pkg::PCM_W-1:0]    rsp_right_pcm
);

   localparam int DEPTH  = mixacc_pkg::BUS_COUNT * FRAME_SAMPLES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WORD_W = mixacc_pkg::WORD_W;
   localparam int VPROD_W = WORD_W + mixacc_pkg::VOLUME_W + 1;
   localparam int RPROD_W = mixacc_pkg::INDEX_W + mixacc_pkg::STEP_W + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_APPLY
   } state_type;

   state_type                              state_ff;
   logic [ADDR_W-1:0]                      clr_ff;
   logic [1:0]                             step_ff;
   logic [1:0]                             last_ff;
   logic                                   ok_ff;
   mixacc_pkg::cmd_type                    cmd_ff;
   logic [mixacc_pkg::BUS_W-1:0]           bus_ff;
   logic [mixacc_pkg::INDEX_W-1:0]         idx_ff;
   logic signed [WORD_W-1:0]               smp_ff;
   logic [mixacc_pkg::VOLUME_W-1:0]        vol_ff;
   logic signed [WORD_W-1:0]               rstart_ff;
   logic signed [mixacc_pkg::STEP_W-1:0]   rstep_ff;
   logic signed [VPROD_W-1:0]              vprod_ff;
   logic signed [RPROD_W-1:0]              rprod_ff;
   logic                                   rsp_strobe_ff;
   logic [WORD_W-1:0]                      word_ff;
   logic [mixacc_pkg::PCM_W-1:0]           left_ff;
   logic [mixacc_pkg::PCM_W-1:0]           right_ff;

   mixacc_pkg::cmd_type                    req_cmd_in;
   logic                                   ok_in;
   logic [1:0]                             last_in;
   logic signed [VPROD_W-1:0]              vprod_in;
   logic signed [RPROD_W-1:0]              rprod_in;
   logic [mixacc_pkg::BUS_W-1:0]           bus_sel;
   logic [ADDR_W-1:0]                      acc_addr;
   logic                                   ram_we;
   logic                                   ram_re;
   logic [ADDR_W-1:0]                      ram_waddr;
   logic [WORD_W-1:0]                      ram_wdata;
   logic [WORD_W-1:0]                      ram_rdata;
   logic [WORD_W-1:0]                      new_word;
   logic                                   cmd_writes;
   logic                                   last_step;
   logic                                   accept;

   // Saturate a stored word to the symmetric 16-bit PCM range.
   function automatic logic [mixacc_pkg::PCM_W-1:0] clamp_pcm(input logic [WORD_W-1:0] x);
      logic signed [WORD_W-1:0] v;
      v = $signed(x);
      if (v < -mixacc_pkg::PCM_MAX) begin
         v = WORD_W'(-mixacc_pkg::PCM_MAX);
      end else if (v > mixacc_pkg::PCM_MAX) begin
         v = WORD_W'(mixacc_pkg::PCM_MAX);
      end
      return v[mixacc_pkg::PCM_W-1:0];
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Decode the incoming command: range check and number of store accesses.
   always_comb begin
      req_cmd_in = mixacc_pkg::cmd_type'(req_cmd);
      ok_in      = 1'b0;
      last_in    = 2'd0;
      unique case (req_cmd_in)
         mixacc_pkg::CMD_SET_MAIN, mixacc_pkg::CMD_SET_OPP, mixacc_pkg::CMD_PCM_OUT: begin
            ok_in   = int'(req_index) < FRAME_SAMPLES;
            last_in = 2'd2;
         end
         mixacc_pkg::CMD_AUXB_MIX: begin
            ok_in   = (int'(req_index) < FRAME_SAMPLES) && (int'(req_bus) < 2);
            last_in = 2'd1;
         end
         mixacc_pkg::CMD_RAMP, mixacc_pkg::CMD_VOL_MIX, mixacc_pkg::CMD_ADD,
         mixacc_pkg::CMD_READ: begin
            ok_in = (int'(req_index) < FRAME_SAMPLES) &&
                    (int'(req_bus) < mixacc_pkg::BUS_COUNT);
         end
      endcase
   end

   // Products of the latched command; registered before use in the apply cycle.
   // A signed product followed by an arithmetic shift rounds toward minus
   // infinity, which matches scaling the magnitude and rounding it up when negative.
   always_comb begin
      vprod_in = smp_ff * $signed({1'b0, vol_ff});
      rprod_in = $signed({1'b0, idx_ff}) * rstep_ff;
   end

   // Bus selected by the current access of each command.
   always_comb begin
      bus_sel = bus_ff;
      unique case (cmd_ff)
         mixacc_pkg::CMD_SET_MAIN, mixacc_pkg::CMD_SET_OPP: begin
            bus_sel = mixacc_pkg::BUS_MAIN_L + mixacc_pkg::BUS_W'(step_ff);
         end
         mixacc_pkg::CMD_AUXB_MIX: begin
            bus_sel = (step_ff == 2'd0) ? mixacc_pkg::BUS_AUXB_L + bus_ff : bus_ff;
         end
         mixacc_pkg::CMD_PCM_OUT: begin
            priority case (step_ff)
               2'd0:    bus_sel = mixacc_pkg::BUS_MAIN_S;
               2'd1:    bus_sel = mixacc_pkg::BUS_MAIN_L;
               default: bus_sel = mixacc_pkg::BUS_MAIN_R;
            endcase
         end
         mixacc_pkg::CMD_RAMP, mixacc_pkg::CMD_VOL_MIX, mixacc_pkg::CMD_ADD,
         mixacc_pkg::CMD_READ: begin
            bus_sel = bus_ff;
         end
      endcase
      acc_addr = ADDR_W'(int'(bus_sel) * FRAME_SAMPLES + int'(idx_ff));
   end

   // Value written back by the current access.
   always_comb begin
      new_word   = '0;
      cmd_writes = 1'b1;
      unique case (cmd_ff)
         mixacc_pkg::CMD_RAMP: begin
            new_word = (rstart_ff == '0) ? '0 :
                       rstart_ff + WORD_W'(rprod_ff);
         end
         mixacc_pkg::CMD_VOL_MIX: begin
            new_word = ram_rdata +
                       vprod_ff[mixacc_pkg::Q_SHIFT +: WORD_W];
         end
         mixacc_pkg::CMD_ADD: begin
            new_word = ram_rdata + smp_ff;
         end
         mixacc_pkg::CMD_SET_MAIN: begin
            new_word = (step_ff == 2'd2) ? '0 : smp_ff;
         end
         mixacc_pkg::CMD_SET_OPP: begin
            priority case (step_ff)
               2'd0:    new_word = -smp_ff;
               2'd1:    new_word = smp_ff;
               default: new_word = '0;
            endcase
         end
         mixacc_pkg::CMD_AUXB_MIX: begin
            new_word = (step_ff == 2'd0) ? smp_ff : ram_rdata + smp_ff;
         end
         mixacc_pkg::CMD_READ, mixacc_pkg::CMD_PCM_OUT: begin
            cmd_writes = 1'b0;
         end
      endcase
   end

   // Memory port control: clearing pass after reset, then command accesses.
   assign last_step = (step_ff == last_ff) || !ok_ff;
   assign ram_re    = (state_ff == ST_ISSUE) && ok_ff;
   assign ram_we    = (state_ff == ST_CLEAR) ||
                      ((state_ff == ST_APPLY) && ok_ff && cmd_writes);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : acc_addr;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : new_word;

   mixacc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (acc_addr),
      .rd_data (ram_rdata)
   );

   // Sequencer state, latched command and registered results.
   always_ff @(posedge clock) begin
      vprod_ff <= vprod_in;
      rprod_ff <= rprod_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         step_ff       <= 2'd0;
         cmd_ff        <= mixacc_pkg::CMD_RAMP;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff    <= req_cmd_in;
                  bus_ff    <= req_bus;
                  idx_ff    <= req_index;
                  smp_ff    <= req_sample;
                  vol_ff    <= req_volume;
                  rstart_ff <= req_ramp_start;
                  rstep_ff  <= req_ramp_step;
                  ok_ff     <= ok_in;
                  last_ff   <= last_in;
                  step_ff   <= 2'd0;
                  word_ff   <= '0;
                  left_ff   <= '0;
                  right_ff  <= '0;
                  state_ff  <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (ok_ff && (cmd_ff == mixacc_pkg::CMD_READ)) begin
                  word_ff <= ram_rdata;
               end
               if (ok_ff && (cmd_ff == mixacc_pkg::CMD_PCM_OUT)) begin
                  priority case (step_ff)
                     2'd0:    word_ff  <= ram_rdata;
                     2'd1:    left_ff  <= clamp_pcm(ram_rdata);
                     default: right_ff <= clamp_pcm(ram_rdata);
                  endcase
               end
               if (last_step) begin
                  rsp_strobe_ff <= (cmd_ff == mixacc_pkg::CMD_READ) ||
                                   (cmd_ff == mixacc_pkg::CMD_PCM_OUT);
                  state_ff      <= ST_IDLE;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_ISSUE;
               end
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_word      = $signed(word_ff);
   assign rsp_left_pcm  = $signed(left_ff);
   assign rsp_right_pcm = $signed(right_ff);

`ifndef SYNTHESIS
   // An accepted command keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted command did not raise busy");

   // A result only appears once the sequencer is back at idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while the sequencer is busy");

   // Results are single-cycle pulses.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // The store is written only by the clearing pass or in an apply cycle.
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_APPLY)))
      else $error("store written outside the clearing pass or apply cycle");
`endif

endmodule

### tb/audio_mix_bus_accumulator_checker.sv
// Checker for the mix bus accumulator: mirrors the bus store and compares each readback.
`timescale 1ns / 100ps
module audio_mix_bus_checker #(
   parameter int FRAME_SAMPLES = mixacc_pkg::FRAME_SAMPLES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic        [mixacc_pkg::CMD_W-1:0]    req_cmd,
   input  logic        [mixacc_pkg::BUS_W-1:0]    req_bus,
   input  logic        [mixacc_pkg::INDEX_W-1:0]  req_index,
   input  logic signed [mixacc_pkg::WORD_W-1:0]   req_sample,
   input  logic        [mixacc_pkg::VOLUME_W-1:0] req_volume,
   input  logic signed [mixacc_pkg::WORD_W-1:0]   req_ramp_start,
   input  logic signed [mixacc_pkg::STEP_W-1:0]   req_ramp_step,
   input  logic                                   rsp_strobe,
   input  logic signed [mixacc_pkg::WORD_W-1:0]   rsp_word,
   input  logic signed [mixacc_pkg::PCM_W-1:0]    rsp_left_pcm,
   input  logic signed [mixacc_pkg::PCM_W-1:0]    rsp_right_pcm,
   output int                                     mismatch_count,
   output int                                     readbacks_waiting,
   output int                                     transfers_seen,
   output int                                     readbacks_seen
);

   localparam int WORD_W   = mixacc_pkg::WORD_W;
   localparam int PCM_W    = mixacc_pkg::PCM_W;
   localparam int BUS_W    = mixacc_pkg::BUS_W;
   localparam int INDEX_W  = mixacc_pkg::INDEX_W;
   localparam int VOLUME_W = mixacc_pkg::VOLUME_W;
   localparam int STEP_W   = mixacc_pkg::STEP_W;

   // One predicted readback, tagged with the command that asked for it.
   typedef struct packed {
      mixacc_pkg::cmd_type op;
      logic [WORD_W-1:0]   word;
      logic [PCM_W-1:0]    left_pcm;
      logic [PCM_W-1:0]    right_pcm;
   } readback_type;

   logic [WORD_W-1:0] mix_image [0:mixacc_pkg::BUS_COUNT*FRAME_SAMPLES-1];
   readback_type      readback_queue [$];
   readback_type      oldest;
   int                mismatch_total;
   int                transfer_total;
   int                readback_total;

   // Flat position of one element in the store image.
   function automatic int slot(input logic [BUS_W-1:0] bus, input logic [INDEX_W-1:0] idx);
      return int'(bus) * FRAME_SAMPLES + int'(idx);
   endfunction

   // Main bus value limited to the symmetric 16-bit output range.
   function automatic logic [PCM_W-1:0] clamp_to_pcm(input logic [WORD_W-1:0] value);
      int level;
      level = $signed(value);
      if (level < -mixacc_pkg::PCM_MAX) level = -mixacc_pkg::PCM_MAX;
      if (level > mixacc_pkg::PCM_MAX) level = mixacc_pkg::PCM_MAX;
      return level[PCM_W-1:0];
   endfunction

   // Sample times Q1.15 gain; the arithmetic shift rounds toward minus infinity.
   function automatic logic [WORD_W-1:0] volume_scaled(input logic [WORD_W-1:0] smp,
                                                       input logic [VOLUME_W-1:0] vol);
      longint product;
      product = longint'($signed(smp)) * longint'(vol);
      product = product >>> mixacc_pkg::Q_SHIFT;
      return product[WORD_W-1:0];
   endfunction

   // Ramp element at this position; a zero start value always gives zero.
   function automatic logic [WORD_W-1:0] ramp_value(input logic [WORD_W-1:0] first,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [STEP_W-1:0] step);
      logic [WORD_W-1:0] step_wide;
      step_wide = {{(WORD_W-STEP_W){step[STEP_W-1]}}, step};
      if (first == '0) return '0;
      return first + {{(WORD_W-INDEX_W){1'b0}}, idx} * step_wide;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_total++;
   endtask

   // Apply one accepted command to the store image and queue any readback it gives.
   task automatic model_mix_command(input mixacc_pkg::cmd_type op,
                                    input logic [BUS_W-1:0] bus,
                                    input logic [INDEX_W-1:0] idx,
                                    input logic [WORD_W-1:0] smp,
                                    input logic [VOLUME_W-1:0] vol,
                                    input logic [WORD_W-1:0] first,
                                    input logic [STEP_W-1:0] step);
      bit           idx_ok;
      bit           bus_ok;
      readback_type rb;
      idx_ok = idx < FRAME_SAMPLES;
      bus_ok = bus < mixacc_pkg::BUS_COUNT;
      rb     = '0;
      rb.op  = op;
      case (op)
         mixacc_pkg::CMD_RAMP: begin
            if (idx_ok && bus_ok) mix_image[slot(bus, idx)] = ramp_value(first, idx, step);
         end
         mixacc_pkg::CMD_VOL_MIX: begin
            if (idx_ok && bus_ok) mix_image[slot(bus, idx)] += volume_scaled(smp, vol);
         end
         mixacc_pkg::CMD_ADD: begin
            if (idx_ok && bus_ok) mix_image[slot(bus, idx)] += smp;
         end
         mixacc_pkg::CMD_READ: begin
            if (idx_ok && bus_ok) rb.word = mix_image[slot(bus, idx)];
            readback_queue.push_back(rb);
         end
         mixacc_pkg::CMD_SET_MAIN, mixacc_pkg::CMD_SET_OPP: begin
            // The bus field plays no part here.
            if (idx_ok) begin
               mix_image[slot(mixacc_pkg::BUS_MAIN_L, idx)] =
                  (op == mixacc_pkg::CMD_SET_MAIN) ? smp : '0 - smp;
               mix_image[slot(mixacc_pkg::BUS_MAIN_R, idx)] = smp;
               mix_image[slot(mixacc_pkg::BUS_MAIN_S, idx)] = '0;
            end
         end
         mixacc_pkg::CMD_AUXB_MIX: begin
            // Selector 0 is the left side, 1 the right; anything else does nothing.
            if (idx_ok && bus < 2) begin
               mix_image[slot(mixacc_pkg::BUS_AUXB_L + bus, idx)] = smp;
               mix_image[slot(bus, idx)] += smp;
            end
         end
         mixacc_pkg::CMD_PCM_OUT: begin
            if (idx_ok) begin
               rb.word      = mix_image[slot(mixacc_pkg::BUS_MAIN_S, idx)];
               rb.left_pcm  = clamp_to_pcm(mix_image[slot(mixacc_pkg::BUS_MAIN_L, idx)]);
               rb.right_pcm = clamp_to_pcm(mix_image[slot(mixacc_pkg::BUS_MAIN_R, idx)]);
            end
            readback_queue.push_back(rb);
         end
      endcase
   endtask

   // Results are compared before the same edge's command transfer is modeled.
   always @(posedge clock) begin
      if (reset) begin
         foreach (mix_image[i]) mix_image[i] = '0;
         readback_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (readback_queue.size() == 0) begin
               report_mismatch($sformatf("result word %h with nothing outstanding", rsp_word));
            end else begin
               oldest = readback_queue.pop_front();
               readback_total++;
               if (rsp_word !== oldest.word)
                  report_mismatch($sformatf("%s word got %h, wanted %h",
                                            oldest.op.name(), rsp_word, oldest.word));
               if (rsp_left_pcm !== oldest.left_pcm)
                  report_mismatch($sformatf("%s left_pcm got %h, wanted %h",
                                            oldest.op.name(), rsp_left_pcm, oldest.left_pcm));
               if (rsp_right_pcm !== oldest.right_pcm)
                  report_mismatch($sformatf("%s right_pcm got %h, wanted %h",
                                            oldest.op.name(), rsp_right_pcm, oldest.right_pcm));
            end
         end
         if (start && !busy) begin
            transfer_total++;
            model_mix_command(mixacc_pkg::cmd_type'(req_cmd), req_bus, req_index, req_sample,
                              req_volume, req_ramp_start, req_ramp_step);
         end
      end
      // Counts are published at the edge so that the top reads settled values.
      mismatch_count    <= mismatch_total;
      readbacks_waiting <= readback_queue.size();
      transfers_seen    <= transfer_total;
      readbacks_seen    <= readback_total;
   end

endmodule

### tb/audio_mix_bus_accumulator_tb.sv
// Testbench top for the mix bus accumulator: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module audio_mix_bus_accumulator_tb;

   localparam int FRAME       = mixacc_pkg::FRAME_SAMPLES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int CMD_W       = mixacc_pkg::CMD_W;
   localparam int BUS_W       = mixacc_pkg::BUS_W;
   localparam int INDEX_W     = mixacc_pkg::INDEX_W;
   localparam int WORD_W      = mixacc_pkg::WORD_W;
   localparam int VOLUME_W    = mixacc_pkg::VOLUME_W;
   localparam int STEP_W      = mixacc_pkg::STEP_W;
   localparam int PCM_W       = mixacc_pkg::PCM_W;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       start          = 1'b0;
   logic                       busy;
   logic        [CMD_W-1:0]    req_cmd        = '0;
   logic        [BUS_W-1:0]    req_bus        = '0;
   logic        [INDEX_W-1:0]  req_index      = '0;
   logic signed [WORD_W-1:0]   req_sample     = '0;
   logic        [VOLUME_W-1:0] req_volume     = '0;
   logic signed [WORD_W-1:0]   req_ramp_start = '0;
   logic signed [STEP_W-1:0]   req_ramp_step  = '0;
   logic                       rsp_strobe;
   logic signed [WORD_W-1:0]   rsp_word;
   logic signed [PCM_W-1:0]    rsp_left_pcm;
   logic signed [PCM_W-1:0]    rsp_right_pcm;
   int                         mismatch_count;
   int                         readbacks_waiting;
   int                         transfers_seen;
   int                         readbacks_seen;
   int                         idle_pct = 0;
   int                         cycle_count = 0;

   audio_mix_bus_accumulator #(.FRAME_SAMPLES(FRAME)) dut (.*);

   audio_mix_bus_checker #(.FRAME_SAMPLES(FRAME)) u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the whole run, including the clearing pass after reset.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one command, maybe after idle cycles, and hold it until the transfer happens.
   task automatic send_command(input mixacc_pkg::cmd_type op, input logic [BUS_W-1:0] bus,
                               input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] smp,
                               input logic [VOLUME_W-1:0] vol,
                               input logic [WORD_W-1:0] first,
                               input logic [STEP_W-1:0] step);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_cmd        <= op;
      req_bus        <= bus;
      req_index      <= idx;
      req_sample     <= smp;
      req_volume     <= vol;
      req_ramp_start <= first;
      req_ramp_step  <= step;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Random command, biased toward valid buses and a few shared positions.
   task automatic send_random_command();
      mixacc_pkg::cmd_type  op;
      logic [BUS_W-1:0]     bus;
      logic [INDEX_W-1:0]   idx;
      logic [WORD_W-1:0]    first;
      logic [VOLUME_W-1:0]  vol;
      op = mixacc_pkg::cmd_type'($urandom_range(7));
      if ($urandom_range(9) == 0)
         bus = BUS_W'($urandom_range(15));
      else if (op == mixacc_pkg::CMD_AUXB_MIX)
         bus = BUS_W'($urandom_range(1));
      else
         bus = BUS_W'($urandom_range(mixacc_pkg::BUS_COUNT - 1));
      case ($urandom_range(9))
         0:          idx = INDEX_W'($urandom_range(255));
         1, 2, 3, 4: idx = INDEX_W'($urandom_range(3));
         default:    idx = INDEX_W'($urandom_range(FRAME - 1));
      endcase
      first = ($urandom_range(7) == 0) ? '0 : $urandom();
      case ($urandom_range(3))
         0:       vol = '1;
         1:       vol = 16'h8000;
         default: vol = VOLUME_W'($urandom());
      endcase
      send_command(op, bus, idx, $urandom(), vol, first, STEP_W'($urandom()));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands: wrapping ramps, gain extremes, clamps and ignored targets.
      idle_pct = 38;
      send_command(mixacc_pkg::CMD_RAMP, 4'd0, 8'd5, '0, '0, 32'h7fffffff, 16'h8000);
      send_command(mixacc_pkg::CMD_READ, 4'd0, 8'd5, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_ADD, 4'd3, 8'd159, 32'd100, '0, '0, '0);
      send_command(mixacc_pkg::CMD_RAMP, 4'd3, 8'd159, '0, '0, '0, 16'h7fff);
      send_command(mixacc_pkg::CMD_READ, 4'd3, 8'd159, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_VOL_MIX, 4'd1, 8'd0, 32'h80000000, 16'hffff, '0, '0);
      send_command(mixacc_pkg::CMD_VOL_MIX, 4'd1, 8'd0, 32'hffffffff, 16'h0001, '0, '0);
      send_command(mixacc_pkg::CMD_READ, 4'd1, 8'd0, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_ADD, 4'd8, 8'd159, 32'h7fffffff, '0, '0, '0);
      send_command(mixacc_pkg::CMD_ADD, 4'd8, 8'd159, 32'h7fffffff, '0, '0, '0);
      send_command(mixacc_pkg::CMD_READ, 4'd8, 8'd159, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_SET_MAIN, 4'd15, 8'd10, 32'd100000, '0, '0, '0);
      send_command(mixacc_pkg::CMD_PCM_OUT, 4'd0, 8'd10, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_SET_OPP, 4'd0, 8'd11, 32'h80000000, '0, '0, '0);
      send_command(mixacc_pkg::CMD_AUXB_MIX, 4'd0, 8'd11, 32'd5, '0, '0, '0);
      send_command(mixacc_pkg::CMD_AUXB_MIX, 4'd1, 8'd11, 32'hfffffffb, '0, '0, '0);
      send_command(mixacc_pkg::CMD_AUXB_MIX, 4'd2, 8'd11, 32'd77, '0, '0, '0);
      send_command(mixacc_pkg::CMD_PCM_OUT, 4'd0, 8'd11, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_READ, 4'd6, 8'd11, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_READ, 4'd7, 8'd11, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_ADD, 4'd9, 8'd0, 32'd1234, '0, '0, '0);
      send_command(mixacc_pkg::CMD_READ, 4'd15, 8'd0, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_ADD, 4'd0, 8'd200, 32'd1, '0, '0, '0);
      send_command(mixacc_pkg::CMD_READ, 4'd0, 8'd255, '0, '0, '0, '0);
      send_command(mixacc_pkg::CMD_PCM_OUT, 4'd0, 8'd160, '0, '0, '0, '0);

      // Random commands in three gap regimes, the last one back to back.
      for (int n = 0; n < 340; n++) send_random_command();
      idle_pct = 48;
      for (int n = 0; n < 340; n++) send_random_command();
      idle_pct = 0;
      for (int n = 0; n < 340; n++) send_random_command();
      start <= 1'b0;

      // Drain outstanding readbacks, then allow a full command time for strays.
      @(posedge clock);
      while (readbacks_waiting != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Covered %0d command transfers over all eight commands, including", transfers_seen);
      $display("out-of-range buses and positions, with %0d readbacks checked.", readbacks_seen);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
